// ----- rtl/pgsv_pkg.sv -----
// Shared constants, types and helpers of the pair gradient scatter and virial unit.
package pgsv_pkg;

  localparam int unsigned ATOM_COUNT = 1024;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned ATOM_W     = $clog2(ATOM_COUNT);
  localparam int unsigned GRAD_W     = 48;
  localparam int unsigned VIR_W      = 64;
  localparam int unsigned IN_W       = 216;
  localparam int unsigned OUT_W      = 200;

  typedef enum logic [1:0] {
    REQ_ACC   = 2'd0,
    REQ_RDG   = 2'd1,
    REQ_RDT   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic {
    CFG_GRAD_EN = 1'b0,
    CFG_VIR_EN  = 1'b1
  } cfg_idx_e;

  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic signed [VIR_W-1:0]  vir_t;
  typedef grad_t [2:0] grad_vec_t;
  typedef vir_t  [2:0] vir_row_t;

  // Only the low VALUE_BITS bits of a value field count, as a two's complement number.
  function automatic logic signed [31:0] take_value(input logic [31:0] raw);
    logic signed [VALUE_BITS-1:0] v;
    v = raw[VALUE_BITS-1:0];
    return 32'(v);
  endfunction

endpackage

// ----- rtl/pair_gradient_scatter_virial_unit.sv -----
// Pair gradient scatter with saturating per-atom gradient and virial tensor accumulation.
// Accumulate: the two gradient read-modify-writes (atom j, then atom i), then the virial
// (one 32x32 multiplier, three products per tensor row); no new item is taken until it ends.
// Reads: the result register takes the registered memory word once the output is free.
// After reset and after a clear item a sweep over all addresses zeroes both memories;
// no item is taken during it, configuration writes are.
module pair_gradient_scatter_virial_unit
  import pgsv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic             cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // req_type, atom_i, atom_j, grad_x, grad_y, grad_z, sep_x, sep_y, sep_z, tensor_row
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // value_x, value_y, value_z, overflow, zero padding
  output logic [OUT_W-1:0] m_axis_tdata
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_GJ, S_GI, S_VM, S_VW, S_RG, S_RT
  } state_e;

  state_e state_q;
  logic   grad_en_q, vir_en_q, ovf_q;
  logic [ATOM_W-1:0] ai_q, aj_q, cnt_q;
  logic              rng_q;
  logic [1:0]        row_q, col_q;
  logic signed [31:0] g_q [3];
  logic signed [31:0] d_q [3];
  vir_row_t  prod_q;
  grad_vec_t fwd_q;
  logic      out_valid_q;
  vir_row_t  out_val_q;
  logic      out_ovf_q;

  // Memories.
  grad_vec_t gmem [ATOM_COUNT];
  vir_row_t  vmem [3];
  grad_vec_t gm_rdata_q;
  vir_row_t  vm_rdata_q;
  logic              gm_rd_en, gm_we, vm_rd_en, vm_we;
  logic [ATOM_W-1:0] gm_rd_addr, gm_waddr;
  logic [1:0]        vm_rd_addr;
  grad_vec_t         gm_wdata;
  vir_row_t          vm_wdata;

  // Input fields.
  logic [1:0]        in_req;
  logic [9:0]        in_ai, in_aj;
  logic [1:0]        in_row;
  logic              in_xfer, in_ai_rng, in_pair_rng;
  assign in_req  = s_axis_tdata[1:0];
  assign in_ai   = s_axis_tdata[11:2];
  assign in_aj   = s_axis_tdata[21:12];
  assign in_row  = s_axis_tdata[215:214];
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign in_ai_rng   = 32'(in_ai) < ATOM_COUNT;
  assign in_pair_rng = in_ai_rng && (32'(in_aj) < ATOM_COUNT);
  assign s_axis_tready = (state_q == S_IDLE);

  // Gradient update: add g to atom j, then subtract it from atom i.
  grad_vec_t grad_base, grad_new;
  logic [2:0] grad_ovf;
  always_comb begin
    logic signed [GRAD_W:0] delta, sum;
    grad_base = ((state_q == S_GI) && (ai_q == aj_q)) ? fwd_q : gm_rdata_q;
    for (int k = 0; k < 3; k++) begin
      delta = (GRAD_W+1)'(g_q[k]);
      if (state_q == S_GI) delta = -delta;
      sum = (GRAD_W+1)'(grad_base[k]) + delta;
      grad_ovf[k] = sum[GRAD_W] != sum[GRAD_W-1];
      if (grad_ovf[k]) begin
        grad_new[k] = sum[GRAD_W] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
      end else begin
        grad_new[k] = sum[GRAD_W-1:0];
      end
    end
  end

  vir_row_t   vir_new;
  logic [2:0] vir_ovf;
  always_comb begin
    logic signed [VIR_W:0] sum;
    for (int k = 0; k < 3; k++) begin
      sum = (VIR_W+1)'(vm_rdata_q[k]) + (VIR_W+1)'(prod_q[k]);
      vir_ovf[k] = sum[VIR_W] != sum[VIR_W-1];
      if (vir_ovf[k]) begin
        vir_new[k] = sum[VIR_W] ? {1'b1, {(VIR_W-1){1'b0}}} : {1'b0, {(VIR_W-1){1'b1}}};
      end else begin
        vir_new[k] = sum[VIR_W-1:0];
      end
    end
  end

  logic out_free, out_load, out_valid_d;
  assign out_free    = !out_valid_q || m_axis_tready;
  assign out_load    = out_free && (state_q == S_RG || state_q == S_RT);
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_comb begin
    gm_rd_en   = 1'b0;
    gm_rd_addr = ai_q;
    gm_we      = 1'b0;
    gm_waddr   = aj_q;
    gm_wdata   = grad_new;
    vm_rd_en   = 1'b0;
    vm_rd_addr = row_q;
    vm_we      = 1'b0;
    vm_wdata   = vir_new;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_req == REQ_ACC && grad_en_q && in_pair_rng) begin
            gm_rd_en   = 1'b1;
            gm_rd_addr = in_aj[ATOM_W-1:0];
          end else if (in_req == REQ_RDG && in_ai_rng) begin
            gm_rd_en   = 1'b1;
            gm_rd_addr = in_ai[ATOM_W-1:0];
          end else if (in_req == REQ_RDT && in_row != 2'd3) begin
            vm_rd_en   = 1'b1;
            vm_rd_addr = in_row;
          end
        end
      end
      S_GJ: begin
        gm_we    = 1'b1;
        gm_rd_en = 1'b1;
      end
      S_GI: begin
        gm_we    = 1'b1;
        gm_waddr = ai_q;
      end
      S_VM: vm_rd_en = (col_q == 2'd2);
      S_VW: vm_we = 1'b1;
      S_CLEAR: begin
        gm_we      = 1'b1;
        gm_waddr   = cnt_q;
        gm_wdata   = '0;
        vm_we      = 32'(cnt_q) < 3;
        vm_rd_addr = cnt_q[1:0];
        vm_wdata   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (gm_we) gmem[gm_waddr] <= gm_wdata;
    if (gm_rd_en) gm_rdata_q <= gmem[gm_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (vm_we) vmem[vm_rd_addr] <= vm_wdata;
    if (vm_rd_en) vm_rdata_q <= vmem[vm_rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grad_en_q <= 1'b1;
      vir_en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRAD_EN: grad_en_q <= cfg_wdata_i;
        CFG_VIR_EN:  vir_en_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ai_q <= in_ai[ATOM_W-1:0];
      aj_q <= in_aj[ATOM_W-1:0];
      for (int k = 0; k < 3; k++) begin
        g_q[k] <= take_value(s_axis_tdata[22+32*k +: 32]);
        d_q[k] <= take_value(s_axis_tdata[118+32*k +: 32]);
      end
    end
    if (state_q == S_GJ) fwd_q <= grad_new;
    if (state_q == S_VM) prod_q[col_q] <= 64'(g_q[col_q] * d_q[row_q]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      rng_q       <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (32'(cnt_q) == ATOM_COUNT - 1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_xfer) begin
            row_q <= '0;
            col_q <= '0;
            case (in_req)
              REQ_ACC: begin
                if (grad_en_q && in_pair_rng) state_q <= S_GJ;
                else if (vir_en_q)            state_q <= S_VM;
              end
              REQ_RDG: begin
                rng_q   <= in_ai_rng;
                state_q <= S_RG;
              end
              REQ_RDT: begin
                rng_q   <= (in_row != 2'd3);
                state_q <= S_RT;
              end
              REQ_CLEAR: begin
                ovf_q   <= 1'b0;
                cnt_q   <= '0;
                state_q <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_GJ: begin
          if (|grad_ovf) ovf_q <= 1'b1;
          state_q <= S_GI;
        end
        S_GI: begin
          if (|grad_ovf) ovf_q <= 1'b1;
          state_q <= vir_en_q ? S_VM : S_IDLE;
        end
        S_VM: begin
          col_q <= col_q + 1'b1;
          if (col_q == 2'd2) state_q <= S_VW;
        end
        S_VW: begin
          if (|vir_ovf) ovf_q <= 1'b1;
          col_q <= '0;
          if (row_q == 2'd2) begin
            state_q <= S_IDLE;
          end else begin
            row_q   <= row_q + 1'b1;
            state_q <= S_VM;
          end
        end
        S_RG: begin
          if (out_free) begin
            out_ovf_q   <= ovf_q;
            for (int k = 0; k < 3; k++) begin
              out_val_q[k] <= rng_q ? VIR_W'(gm_rdata_q[k]) : '0;
            end
            state_q <= S_IDLE;
          end
        end
        S_RT: begin
          if (out_free) begin
            out_ovf_q   <= ovf_q;
            out_val_q   <= rng_q ? vm_rdata_q : '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_ovf_q, out_val_q[2], out_val_q[1], out_val_q[0]};

  // A new result is only loaded from one of the two read states.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == S_RG || $past(state_q) == S_RT))
    else $error("result appeared outside a read state");

  // The flag stays clear for the whole clearing sweep.
  a_clear_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && $past(state_q) == S_CLEAR) |-> !ovf_q)
    else $error("overflow flag set during clear");

  // Each tensor row is written only after all three products are formed.
  a_vw_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VW) |-> ($past(state_q) == S_VM && $past(col_q) == 2'd2))
    else $error("virial row written before its products");

endmodule

// ----- dv/pair_gradient_scatter_virial_unit_test.sv -----
// Self-checking testbench for the pair gradient scatter and virial unit.
module pair_gradient_scatter_virial_unit_test;
  import pgsv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint GRAD_HI = (longint'(1) << 47) - 1;
  localparam longint GRAD_LO = -(longint'(1) << 47);
  localparam int SWEEP_WAIT = ATOM_COUNT + 100;
  localparam longint CYCLE_LIMIT = 4000000;

  // Fields listed from the top bit down, so req_type lands in the lowest bits.
  typedef struct packed {
    logic [1:0]        row;
    logic signed [31:0] sz, sy, sx;
    logic signed [31:0] gz, gy, gx;
    logic [9:0]        aj, ai;
    req_e              req;
  } pair_req_t;

  typedef struct packed {
    logic [6:0]         pad;
    logic               ovf;
    logic signed [63:0] vz, vy, vx;
  } readout_t;

  typedef struct {
    pair_req_t it;
    bit        typed;
    readout_t  want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  pair_gradient_scatter_virial_unit uut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow state of the unit.
  longint grad_x_sh[ATOM_COUNT], grad_y_sh[ATOM_COUNT], grad_z_sh[ATOM_COUNT];
  longint virial_sh[9];
  bit     sat_sh;
  bit     grad_en_sh, vir_en_sh;

  readout_t readout_q[$];
  int unsigned errors, items_sent, readouts_seen, clears_sent;
  int unsigned send_idle, recv_idle;
  bit hold_req;
  int unsigned hold_cnt;
  longint cycles;

  function automatic longint grad_sum(longint acc, longint delta);
    longint s;
    s = acc + delta;
    if (s > GRAD_HI) begin
      sat_sh = 1'b1;
      return GRAD_HI;
    end
    if (s < GRAD_LO) begin
      sat_sh = 1'b1;
      return GRAD_LO;
    end
    return s;
  endfunction

  function automatic longint tensor_sum(longint acc, longint delta);
    logic signed [64:0] s;
    s = 65'(acc) + 65'(delta);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      sat_sh = 1'b1;
      return 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    if (s < -65'sh0_8000_0000_0000_0000) begin
      sat_sh = 1'b1;
      return 64'sh8000_0000_0000_0000;
    end
    return longint'(s[63:0]);
  endfunction

  function automatic void clear_shadow();
    foreach (grad_x_sh[a]) begin
      grad_x_sh[a] = 0;
      grad_y_sh[a] = 0;
      grad_z_sh[a] = 0;
    end
    foreach (virial_sh[k]) virial_sh[k] = 0;
    sat_sh = 1'b0;
  endfunction

  // Updates the shadow state for one accepted transfer and queues any readout it causes.
  function automatic void apply_pair(pair_req_t it, bit typed, readout_t want);
    longint g[3], d[3];
    readout_t r;
    g[0] = it.gx; g[1] = it.gy; g[2] = it.gz;
    d[0] = it.sx; d[1] = it.sy; d[2] = it.sz;
    r = '0;
    case (it.req)
      REQ_ACC: begin
        if (grad_en_sh) begin
          grad_x_sh[it.aj] = grad_sum(grad_x_sh[it.aj], g[0]);
          grad_y_sh[it.aj] = grad_sum(grad_y_sh[it.aj], g[1]);
          grad_z_sh[it.aj] = grad_sum(grad_z_sh[it.aj], g[2]);
          grad_x_sh[it.ai] = grad_sum(grad_x_sh[it.ai], -g[0]);
          grad_y_sh[it.ai] = grad_sum(grad_y_sh[it.ai], -g[1]);
          grad_z_sh[it.ai] = grad_sum(grad_z_sh[it.ai], -g[2]);
        end
        if (vir_en_sh) begin
          for (int rr = 0; rr < 3; rr++)
            for (int c = 0; c < 3; c++)
              virial_sh[3*rr+c] = tensor_sum(virial_sh[3*rr+c], g[c] * d[rr]);
        end
      end
      REQ_CLEAR: begin
        clear_shadow();
        clears_sent++;
      end
      REQ_RDG: begin
        r.vx = grad_x_sh[it.ai];
        r.vy = grad_y_sh[it.ai];
        r.vz = grad_z_sh[it.ai];
        r.ovf = sat_sh;
        readout_q.push_back(typed ? want : r);
      end
      default: begin
        if (it.row < 3) begin
          r.vx = virial_sh[3*it.row];
          r.vy = virial_sh[3*it.row+1];
          r.vz = virial_sh[3*it.row+2];
        end
        r.ovf = sat_sh;
        readout_q.push_back(typed ? want : r);
      end
    endcase
  endfunction

  function automatic pair_req_t mk(req_e req, int ai, int aj, logic [31:0] gx, logic [31:0] gy,
                                   logic [31:0] gz, logic [31:0] sx, logic [31:0] sy,
                                   logic [31:0] sz, int row);
    pair_req_t it;
    it.req = req; it.ai = 10'(ai); it.aj = 10'(aj);
    it.gx = gx; it.gy = gy; it.gz = gz;
    it.sx = sx; it.sy = sy; it.sz = sz;
    it.row = 2'(row);
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    if ($urandom_range(99) < 70) return $urandom;
    return 32'($signed($urandom_range(2000)) - 1000);
  endfunction

  function automatic pair_req_t rand_pair();
    pair_req_t it;
    int unsigned p;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.gx = rand_value(); it.gy = rand_value(); it.gz = rand_value();
    it.sx = rand_value(); it.sy = rand_value(); it.sz = rand_value();
    // Mostly a small set of atoms, so that sums build up and pairs collide.
    if ($urandom_range(99) < 75) begin
      it.ai = 10'($urandom_range(15));
      it.aj = 10'($urandom_range(15));
    end
    p = $urandom_range(99);
    if (p < 58) it.req = REQ_ACC;
    else if (p < 80) it.req = REQ_RDG;
    else if (p < 97) it.req = REQ_RDT;
    else it.req = REQ_CLEAR;
    return it;
  endfunction

  task automatic send_pair(pair_req_t it, bit typed = 1'b0, readout_t want = '0);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_pair(it, typed, want);
    items_sent++;
  endtask

  // Waits for every outstanding readout, then lets a possible clear sweep finish.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk_i);
    repeat (SWEEP_WAIT) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, bit val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_GRAD_EN) grad_en_sh = val;
    else vir_en_sh = val;
  endtask

  task automatic run_phase(bit gen, bit vir, int unsigned sidle, int unsigned ridle,
                           int unsigned count, bit pressure);
    settle();
    write_cfg(CFG_GRAD_EN, gen);
    write_cfg(CFG_VIR_EN, vir);
    send_idle = sidle;
    recv_idle = ridle;
    if (pressure) begin
      hold_req = 1'b1;
      for (int k = 0; k < 40; k++)
        send_pair(mk(REQ_RDG, $urandom_range(15), $urandom, 0, 0, 0, 0, 0, 0, 0));
    end
    for (int k = 0; k < count; k++) send_pair(rand_pair());
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pair_gradient_scatter_virial_unit verification failed");
      $finish;
    end
  end

  // Result side: check each transfer against the oldest expected readout.
  always @(posedge clk_i) begin
    readout_t got, exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        readouts_seen++;
        if (readout_q.size() == 0) begin
          $error("unexpected readout %h", got);
          errors++;
        end else begin
          exp_r = readout_q.pop_front();
          if (got.vx !== exp_r.vx) begin
            $error("value_x expected %h got %h", exp_r.vx, got.vx); errors++;
          end
          if (got.vy !== exp_r.vy) begin
            $error("value_y expected %h got %h", exp_r.vy, got.vy); errors++;
          end
          if (got.vz !== exp_r.vz) begin
            $error("value_z expected %h got %h", exp_r.vz, got.vz); errors++;
          end
          if (got.ovf !== exp_r.ovf) begin
            $error("overflow expected %b got %b", exp_r.ovf, got.ovf); errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    dir_row_t dir[$];
    dir_row_t row;
    readout_t zero_r;
    clear_shadow();
    grad_en_sh = 1'b1;
    vir_en_sh  = 1'b1;
    zero_r = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: reads after reset, extreme values, repeated atoms, tensor saturation.
    row.typed = 1'b1; row.want = zero_r;
    row.it = mk(REQ_RDG, 0, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
    row.it = mk(REQ_RDG, 1023, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
    row.it = mk(REQ_RDT, 0, 0, 0, 0, 0, 0, 0, 0, 3); dir.push_back(row);
    row.typed = 1'b0;
    row.it = mk(REQ_ACC, 0, 1023, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 32'hFFFF_FFFF,
                32'h7FFF_FFFF, 0); dir.push_back(row);
    row.it = mk(REQ_ACC, 1023, 0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 0, 32'h0001_0000, 3); dir.push_back(row);
    row.it = mk(REQ_ACC, 5, 5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 2, 3, 4, 1);
    dir.push_back(row);
    row.it = mk(REQ_RDG, 0, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
    row.it = mk(REQ_RDG, 1023, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
    row.it = mk(REQ_RDG, 5, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
    for (int r = 0; r < 3; r++) begin
      row.it = mk(REQ_RDT, 0, 0, 0, 0, 0, 0, 0, 0, r); dir.push_back(row);
    end
    // Two products of 2^62 each push tensor entries past the top of the range.
    for (int k = 0; k < 2; k++) begin
      row.it = mk(REQ_ACC, 7, 8, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      dir.push_back(row);
    end
    row.it = mk(REQ_RDT, 0, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
    row.it = mk(REQ_RDT, 0, 0, 0, 0, 0, 0, 0, 0, 2); dir.push_back(row);
    row.it = mk(REQ_RDG, 8, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
    row.it = mk(REQ_CLEAR, 1023, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3); dir.push_back(row);
    row.typed = 1'b1;
    row.it = mk(REQ_RDT, 0, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
    row.it = mk(REQ_RDG, 1023, 0, 0, 0, 0, 0, 0, 0, 0); dir.push_back(row);
    foreach (dir[k]) send_pair(dir[k].it, dir[k].typed, dir[k].want);

    run_phase(1, 1, 37, 70, 200, 0);
    run_phase(0, 1, 70, 37, 150, 0);
    run_phase(1, 0, 0, 0, 150, 1);
    run_phase(0, 0, 37, 70, 50, 0);
    run_phase(1, 1, 0, 0, 150, 0);
    settle();

    $display("Sent %0d transfers (%0d clears) over four enable settings and three idle mixes,",
             items_sent, clears_sent);
    $display("checked %0d readouts including tensor saturation and a long output stall.",
             readouts_seen);
    if (errors == 0) begin
      $display("pair_gradient_scatter_virial_unit verification clean");
    end else begin
      $display("pair_gradient_scatter_virial_unit verification failed");
    end
    $finish;
  end

endmodule
